// ===== hdl/imhpq_pkg.sv =====
`default_nettype none

package imhpq_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int KEY_SPACE_DEF     = 64;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam int KEY_BITS      = 6;
    localparam int PRI_WORD_BITS = 16;
    localparam int COUNT_BITS    = 7;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_EXTRACT = 2'd1;
    localparam logic [1:0] REQ_CHANGE  = 2'd2;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_ABSENT = 3'd3,
        STAT_DUP    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]                      req_type;
        logic [KEY_BITS-1:0]             key_id;
        logic signed [PRI_WORD_BITS-1:0] priority_req;
    } req_word_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]             out_key;
        logic signed [PRI_WORD_BITS-1:0] out_priority;
        status_t                         status;
        logic [COUNT_BITS-1:0]           entry_count;
    } rsp_word_t;

endpackage

`default_nettype wire

// ===== hdl/imhpq_ram.sv =====
`default_nettype none

module imhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/indexed_min_heap_priority_queue.sv =====
// A request that only checks goes from acceptance through S_FIN to the registered result
// word; an insert or a rise toward the root steps through S_UP and S_UPW for each level, and
// a sift toward the leaves through S_DN, S_DNL, S_DNR (only when a right child exists) and
// S_DNC for each level. One request is worked at a time; a full sift is paced by the single
// read port of the heap memory, read once per child. Reset clears the entry count and the
// key-present flags at once; the memories need no clearing, and the block is then idle.
`default_nettype none

module indexed_min_heap_priority_queue
    import imhpq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int KEY_SPACE     = KEY_SPACE_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp_word
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(KEY_SPACE);
    localparam int PB = PRIORITY_BITS;
    localparam int HW = PB + KEY_BITS;
    localparam int LW = PW + 2;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_UP   = 12'b000000000010,
        S_UPW  = 12'b000000000100,
        S_EX0  = 12'b000000001000,
        S_EX1  = 12'b000000010000,
        S_DN   = 12'b000000100000,
        S_DNL  = 12'b000001000000,
        S_DNR  = 12'b000010000000,
        S_DNC  = 12'b000100000000,
        S_CH0  = 12'b001000000000,
        S_CH1  = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [KEY_SPACE-1:0]    present_reg, present_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_word_t               rsp_word_reg, rsp_word_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic signed [PB-1:0]    pri_reg, pri_next;
    logic [PW-1:0]           idx_reg, idx_next;
    logic [KEY_BITS-1:0]     cur_key_reg, cur_key_next;
    logic signed [PB-1:0]    cur_pri_reg, cur_pri_next;
    logic [KEY_BITS-1:0]     left_key_reg, left_key_next;
    logic signed [PB-1:0]    left_pri_reg, left_pri_next;
    logic [KEY_BITS-1:0]     right_key_reg, right_key_next;
    logic signed [PB-1:0]    right_pri_reg, right_pri_next;
    logic                    has_r_reg, has_r_next;
    status_t                 status_reg, status_next;
    logic [KEY_BITS-1:0]     okey_reg, okey_next;
    logic signed [PRI_WORD_BITS-1:0] opri_reg, opri_next;

    logic                    heap_we;
    logic [PW-1:0]           heap_wa;
    logic [HW-1:0]           heap_wd;
    logic [PW-1:0]           heap_ra;
    logic [HW-1:0]           heap_rd;
    logic                    pos_we;
    logic [KW-1:0]           pos_wa;
    logic [PW-1:0]           pos_wd;
    logic [KW-1:0]           pos_ra;
    logic [PW-1:0]           pos_rd;

    logic signed [PB-1:0]    rd_pri;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PW-1:0]           parent;
    logic [LW-1:0]           lchild;
    logic [LW-1:0]           rchild;
    logic [LW-1:0]           count_ext;
    logic                    in_range;
    logic                    is_present;
    logic                    accept;
    logic [PW-1:0]           m_idx;
    logic [KEY_BITS-1:0]     m_key;
    logic signed [PB-1:0]    m_pri;

    imhpq_ram #(
        .WIDTH(HW),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (heap_we),
        .wr_addr (heap_wa),
        .wr_data (heap_wd),
        .rd_addr (heap_ra),
        .rd_data (heap_rd)
    );

    imhpq_ram #(
        .WIDTH(PW),
        .DEPTH(KEY_SPACE)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_we),
        .wr_addr (pos_wa),
        .wr_data (pos_wd),
        .rd_addr (pos_ra),
        .rd_data (pos_rd)
    );

    assign rd_pri     = heap_rd[PB-1:0];
    assign rd_key     = heap_rd[HW-1:PB];
    assign parent     = PW'((idx_reg - 1'b1) >> 1);
    assign lchild     = {1'b0, idx_reg, 1'b1};
    assign rchild     = lchild + 1'b1;
    assign count_ext  = LW'(count_reg);
    assign in_range   = 32'(req_word.key_id) < KEY_SPACE;
    assign is_present = in_range && present_reg[KW'(req_word.key_id)];
    assign req_stall  = (state_reg != S_IDLE);
    assign accept     = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_word   = rsp_word_reg;

    always_comb
    begin
        m_idx = idx_reg;
        m_key = cur_key_reg;
        m_pri = cur_pri_reg;
        if (left_pri_reg < m_pri)
        begin
            m_idx = PW'(lchild);
            m_key = left_key_reg;
            m_pri = left_pri_reg;
        end
        if (has_r_reg && (right_pri_reg < m_pri))
        begin
            m_idx = PW'(rchild);
            m_key = right_key_reg;
            m_pri = right_pri_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        present_next   = present_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        key_next       = key_reg;
        pri_next       = pri_reg;
        idx_next       = idx_reg;
        cur_key_next   = cur_key_reg;
        cur_pri_next   = cur_pri_reg;
        left_key_next  = left_key_reg;
        left_pri_next  = left_pri_reg;
        right_key_next = right_key_reg;
        right_pri_next = right_pri_reg;
        has_r_next     = has_r_reg;
        status_next    = status_reg;
        okey_next      = okey_reg;
        opri_next      = opri_reg;
        heap_we        = 1'b0;
        heap_wa        = idx_reg;
        heap_wd        = {cur_key_reg, cur_pri_reg};
        heap_ra        = '0;
        pos_we         = 1'b0;
        pos_wa         = KW'(cur_key_reg);
        pos_wd         = idx_reg;
        pos_ra         = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = req_word.key_id;
                    pri_next    = PB'(req_word.priority_req);
                    status_next = STAT_OK;
                    okey_next   = '0;
                    opri_next   = '0;
                    state_next  = S_FIN;
                    unique case (req_word.req_type)
                        REQ_INSERT:
                        begin
                            if (!in_range)
                            begin
                                status_next = STAT_ABSENT;
                            end
                            else if (is_present)
                            begin
                                status_next = STAT_DUP;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cur_key_next = req_word.key_id;
                                cur_pri_next = PB'(req_word.priority_req);
                                idx_next     = PW'(count_reg);
                                present_next[KW'(req_word.key_id)] = 1'b1;
                                count_next   = count_reg + 1'b1;
                                state_next   = S_UP;
                            end
                        end
                        REQ_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                heap_ra    = '0;
                                state_next = S_EX0;
                            end
                        end
                        REQ_CHANGE:
                        begin
                            if (!is_present)
                            begin
                                status_next = STAT_ABSENT;
                            end
                            else
                            begin
                                pos_ra     = KW'(req_word.key_id);
                                state_next = S_CH0;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                if (idx_reg == '0)
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    heap_ra    = parent;
                    state_next = S_UPW;
                end
            end
            S_UPW:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (rd_pri > cur_pri_reg)
                begin
                    heap_wd    = heap_rd;
                    pos_wa     = KW'(rd_key);
                    idx_next   = parent;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EX0:
            begin
                okey_next  = rd_key;
                opri_next  = PRI_WORD_BITS'(rd_pri);
                present_next[KW'(rd_key)] = 1'b0;
                count_next = count_reg - 1'b1;
                heap_ra    = PW'(count_reg - 1'b1);
                if (count_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_EX1;
                end
            end
            S_EX1:
            begin
                cur_key_next = rd_key;
                cur_pri_next = rd_pri;
                idx_next     = '0;
                state_next   = S_DN;
            end
            S_DN:
            begin
                if (lchild >= count_ext)
                begin
                    heap_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    heap_ra    = PW'(lchild);
                    state_next = S_DNL;
                end
            end
            S_DNL:
            begin
                left_key_next = rd_key;
                left_pri_next = rd_pri;
                if (rchild < count_ext)
                begin
                    heap_ra    = PW'(rchild);
                    has_r_next = 1'b1;
                    state_next = S_DNR;
                end
                else
                begin
                    has_r_next = 1'b0;
                    state_next = S_DNC;
                end
            end
            S_DNR:
            begin
                right_key_next = rd_key;
                right_pri_next = rd_pri;
                state_next     = S_DNC;
            end
            S_DNC:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (m_idx == idx_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    heap_wd    = {m_key, m_pri};
                    pos_wa     = KW'(m_key);
                    idx_next   = m_idx;
                    state_next = S_DN;
                end
            end
            S_CH0:
            begin
                idx_next   = pos_rd;
                heap_ra    = pos_rd;
                state_next = S_CH1;
            end
            S_CH1:
            begin
                cur_key_next = key_reg;
                cur_pri_next = pri_reg;
                if (rd_pri < pri_reg)
                begin
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_UP;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_word_next.out_key      = okey_reg;
                    rsp_word_next.out_priority = opri_reg;
                    rsp_word_next.status       = status_reg;
                    rsp_word_next.entry_count  = COUNT_BITS'(count_reg);
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            present_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            present_reg   <= present_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg  <= rsp_word_next;
        key_reg       <= key_next;
        pri_reg       <= pri_next;
        idx_reg       <= idx_next;
        cur_key_reg   <= cur_key_next;
        cur_pri_reg   <= cur_pri_next;
        left_key_reg  <= left_key_next;
        left_pri_reg  <= left_pri_next;
        right_key_reg <= right_key_next;
        right_pri_reg <= right_pri_next;
        has_r_reg     <= has_r_next;
        status_reg    <= status_next;
        okey_reg      <= okey_next;
        opri_reg      <= opri_next;
    end

endmodule

`default_nettype wire
